// ===== rtl/tga_rle_pixel_decoder_defines.svh =====
// Assertion macros shared by the TGA pixel decoder RTL.
`ifndef TGA_RLE_PIXEL_DECODER_DEFINES_SVH
`define TGA_RLE_PIXEL_DECODER_DEFINES_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define TRPD_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define TRPD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/trpd_pkg.sv =====
// Types and constants of the TGA pixel decoder.
package trpd_pkg;

   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 16;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BYTES_PER_PIXEL = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RUN_LENGTH_MODE = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_IMAGE_WIDTH     = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_IMAGE_HEIGHT    = 2'd3;

   localparam logic [2:0] BPP_WIDE    = 3'd4;
   localparam logic [2:0] BPP_RESET   = 3'd3;
   localparam logic [7:0] RUN_FLAG    = 8'h80;
   localparam logic [7:0] COUNT_MASK  = 8'h7F;
   localparam logic [7:0] RUN_MAX     = 8'h80;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       image_start;
   } trpd_req_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
      logic [7:0] repeat_count;
      logic       image_done;
   } trpd_rsp_type;

   typedef struct packed {
      logic        wide_pixel;
      logic        run_length_mode;
      logic [31:0] total_pixels;
   } trpd_cfg_type;

endpackage

// ===== rtl/trpd_channels.sv =====
// Request and response channel interfaces of the TGA pixel decoder.
interface trpd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       image_start;

   modport source (output valid, data_byte, image_start, input ready);
   modport sink (input valid, data_byte, image_start, output ready);
endinterface

interface trpd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   logic [7:0] alpha;
   logic [7:0] repeat_count;
   logic       image_done;

   modport source (output valid, red, green, blue, alpha, repeat_count, image_done,
                   input ready);
   modport sink (input valid, red, green, blue, alpha, repeat_count, image_done,
                 output ready);
endinterface

// ===== rtl/tga_rle_pixel_decoder.sv =====
// Path: an accepted request waits in the input register, the core decodes it combinationally, and
//    a finished pixel waits in the output register for the response handshake.
// Throughput: one request per cycle while the response slot is free; the core updates all packet state per byte.
// Reset (synchronous, active high): clears channel valids and decode progress, and loads
//    bytes_per_pixel 3, uncompressed mode, width 1, height 1.
// Pixel total is registered from the product of the width and height registers.
module tga_rle_pixel_decoder
   import trpd_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_write_data,
   trpd_req_if.sink                   req_chan,
   trpd_rsp_if.source                 rsp_chan
);

   // configuration registers
   logic [2:0]  bytes_per_pixel_ff;
   logic        run_length_mode_ff;
   logic [15:0] image_width_ff;
   logic [15:0] image_height_ff;
   // pixel count of the image, one register after the multiply
   logic [31:0] total_pixels_ff;
   logic [31:0] total_pixels_in;

   trpd_cfg_type cfg;
   logic         in_valid;
   trpd_req_type in_item;
   logic         take;
   logic         out_free;
   logic         res_valid;
   trpd_rsp_type res;

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_per_pixel_ff <= BPP_RESET;
         run_length_mode_ff <= 1'b0;
         image_width_ff     <= 16'd1;
         image_height_ff    <= 16'd1;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_BYTES_PER_PIXEL: begin
               bytes_per_pixel_ff <= csr_write_data[2:0];
            end
            CSR_RUN_LENGTH_MODE: begin
               run_length_mode_ff <= csr_write_data[0];
            end
            CSR_IMAGE_WIDTH: begin
               image_width_ff <= csr_write_data;
            end
            CSR_IMAGE_HEIGHT: begin
               image_height_ff <= csr_write_data;
            end
            default: begin
            end
         endcase
      end
   end

   // refresh the pixel total every cycle; config is to be written only while idle, which the block does not enforce
   assign total_pixels_in = {16'd0, image_width_ff} * {16'd0, image_height_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         total_pixels_ff <= 32'd1;
      end else begin
         total_pixels_ff <= total_pixels_in;
      end
   end

   // any size other than four bytes decodes as three
   assign cfg.wide_pixel      = bytes_per_pixel_ff == BPP_WIDE;
   assign cfg.run_length_mode = run_length_mode_ff;
   assign cfg.total_pixels    = total_pixels_ff;

   // hold the request until the core can advance it
   trpd_in_stage u_in_stage (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .take     (take),
      .valid    (in_valid),
      .item     (in_item)
   );

   // decode one byte per cycle; advance only when the response slot is free
   trpd_core u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (in_valid),
      .item      (in_item),
      .out_free  (out_free),
      .take      (take),
      .res_valid (res_valid),
      .res       (res)
   );

   // hold each finished pixel until the sink takes it
   trpd_out_stage u_out_stage (
      .clock    (clock),
      .reset    (reset),
      .load     (res_valid),
      .res      (res),
      .out_free (out_free),
      .rsp_chan (rsp_chan)
   );

endmodule

// ===== rtl/trpd_in_stage.sv =====
// Input register stage: holds one request for the decode core.
module trpd_in_stage
   import trpd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   trpd_req_if.sink     req_chan,
   input  logic         take,
   output logic         valid,
   output trpd_req_type item
);

   logic         valid_ff;
   logic         valid_in;
   trpd_req_type item_ff;
   logic         accept;

   assign req_chan.ready = !valid_ff || take;
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      priority if (accept) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (accept) begin
         item_ff.data_byte   <= req_chan.data_byte;
         item_ff.image_start <= req_chan.image_start;
      end
   end

   assign valid = valid_ff;
   assign item  = item_ff;

endmodule

// ===== rtl/trpd_core.sv =====
// Decode core: packet and pixel state, one byte per cycle while the response slot is free.
`include "tga_rle_pixel_decoder_defines.svh"

module trpd_core
   import trpd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  trpd_cfg_type cfg,
   input  logic         in_valid,
   input  trpd_req_type item,
   input  logic         out_free,
   output logic         take,
   output logic         res_valid,
   output trpd_rsp_type res
);

   logic        expect_header_ff, expect_header_in;
   logic        packet_is_run_ff, packet_is_run_in;
   logic [7:0]  packet_left_ff, packet_left_in;
   logic [1:0]  byte_in_pixel_ff, byte_in_pixel_in;
   logic [31:0] pixel_bytes_ff, pixel_bytes_in;
   logic [31:0] pixels_done_ff, pixels_done_in;
   logic        image_finished_ff, image_finished_in;

   // state as seen after an optional image_start clear
   logic        cur_header;
   logic        cur_run;
   logic [7:0]  cur_left;
   logic [1:0]  cur_byte;
   logic [31:0] cur_bytes;
   logic [31:0] cur_done;
   logic        cur_finished;

   logic        skip;
   logic [31:0] remaining;
   logic [31:0] merged;
   logic        complete;
   logic [7:0]  header_count;
   logic [7:0]  header_clip;
   logic [7:0]  run_clip;
   logic [7:0]  left_dec;
   logic [7:0]  count;
   logic        emit;

   assign take = in_valid && out_free;

   assign cur_header   = item.image_start ? 1'b1  : expect_header_ff;
   assign cur_run      = item.image_start ? 1'b0  : packet_is_run_ff;
   assign cur_left     = item.image_start ? 8'd0  : packet_left_ff;
   assign cur_byte     = item.image_start ? 2'd0  : byte_in_pixel_ff;
   assign cur_bytes    = item.image_start ? 32'd0 : pixel_bytes_ff;
   assign cur_done     = item.image_start ? 32'd0 : pixels_done_ff;
   assign cur_finished = item.image_start ? 1'b0  : image_finished_ff;

   assign skip      = cur_finished || (cur_done >= cfg.total_pixels);
   assign remaining = cfg.total_pixels - cur_done;

   // header count: low seven bits plus one, for both packet kinds
   assign header_count = (item.data_byte & COUNT_MASK) + 8'd1;
   assign header_clip  = ({24'd0, header_count} > remaining) ? remaining[7:0] : header_count;
   assign run_clip     = ({24'd0, cur_left} > remaining) ? remaining[7:0] : cur_left;
   assign left_dec     = (cur_left != 8'd0) ? cur_left - 8'd1 : 8'd0;

   always_comb begin
      merged = cur_bytes;
      merged[8*cur_byte +: 8] = item.data_byte;
   end

   assign complete = cfg.wide_pixel ? (cur_byte == 2'd3) : (cur_byte >= 2'd2);

   always_comb begin
      expect_header_in  = cur_header;
      packet_is_run_in  = cur_run;
      packet_left_in    = cur_left;
      byte_in_pixel_in  = cur_byte;
      pixel_bytes_in    = cur_bytes;
      pixels_done_in    = cur_done;
      image_finished_in = cur_finished;
      count             = 8'd1;
      emit              = 1'b0;
      if (!skip) begin
         if (cfg.run_length_mode && cur_header) begin
            packet_is_run_in = (item.data_byte & RUN_FLAG) != 8'd0;
            packet_left_in   = header_clip;
            expect_header_in = 1'b0;
         end else if (!complete) begin
            pixel_bytes_in   = merged;
            byte_in_pixel_in = cur_byte + 2'd1;
         end else begin
            emit = 1'b1;
            if (cfg.run_length_mode) begin
               if (cur_run) begin
                  count            = (run_clip == 8'd0) ? 8'd1 : run_clip;
                  packet_left_in   = 8'd0;
                  expect_header_in = 1'b1;
               end else begin
                  packet_left_in = left_dec;
                  if (left_dec == 8'd0) begin
                     expect_header_in = 1'b1;
                  end
               end
            end
            pixels_done_in    = cur_done + {24'd0, count};
            image_finished_in = {24'd0, count} >= remaining;
            pixel_bytes_in    = 32'd0;
            byte_in_pixel_in  = 2'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expect_header_ff  <= 1'b1;
         packet_is_run_ff  <= 1'b0;
         packet_left_ff    <= 8'd0;
         byte_in_pixel_ff  <= 2'd0;
         pixel_bytes_ff    <= 32'd0;
         pixels_done_ff    <= 32'd0;
         image_finished_ff <= 1'b0;
      end else if (take) begin
         expect_header_ff  <= expect_header_in;
         packet_is_run_ff  <= packet_is_run_in;
         packet_left_ff    <= packet_left_in;
         byte_in_pixel_ff  <= byte_in_pixel_in;
         pixel_bytes_ff    <= pixel_bytes_in;
         pixels_done_ff    <= pixels_done_in;
         image_finished_ff <= image_finished_in;
      end
   end

   assign res_valid        = take && emit;
   assign res.red          = merged[23:16];
   assign res.green        = merged[15:8];
   assign res.blue         = merged[7:0];
   assign res.alpha        = cfg.wide_pixel ? merged[31:24] : 8'd0;
   assign res.repeat_count = count;
   assign res.image_done   = image_finished_in;

   `TRPD_ASSERT_SAME(a_count_range, res_valid,
      res.repeat_count != 8'd0 && res.repeat_count <= RUN_MAX, "repeat count out of range")
   `TRPD_ASSERT_SAME(a_multi_only_rle, res_valid && res.repeat_count != 8'd1,
      cfg.run_length_mode, "repeat count above one in uncompressed mode")
   `TRPD_ASSERT_NEXT(a_done_sticks, res_valid && res.image_done,
      image_finished_ff, "image done not recorded")

endmodule

// ===== rtl/trpd_out_stage.sv =====
// Output register stage: holds one decoded pixel until the sink takes it.
`include "tga_rle_pixel_decoder_defines.svh"

module trpd_out_stage
   import trpd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         load,
   input  trpd_rsp_type res,
   output logic         out_free,
   trpd_rsp_if.source   rsp_chan
);

   logic         valid_ff;
   logic         valid_in;
   trpd_rsp_type res_ff;

   assign out_free = !valid_ff || rsp_chan.ready;

   always_comb begin
      priority if (load) begin
         valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         res_ff <= res;
      end
   end

   assign rsp_chan.valid        = valid_ff;
   assign rsp_chan.red          = res_ff.red;
   assign rsp_chan.green        = res_ff.green;
   assign rsp_chan.blue         = res_ff.blue;
   assign rsp_chan.alpha        = res_ff.alpha;
   assign rsp_chan.repeat_count = res_ff.repeat_count;
   assign rsp_chan.image_done   = res_ff.image_done;

   `TRPD_ASSERT_SAME(a_no_overwrite, valid_ff && !rsp_chan.ready, !load,
      "pending response overwritten")

endmodule
